[hdl/fir_filter_direct_form_macros.svh]
// Assertion macros for the direct-form FIR filter.
// Each macro checks on the rising edge of clk and is disabled while rst is high.
`ifndef FIR_FILTER_DIRECT_FORM_MACROS_SVH
`define FIR_FILTER_DIRECT_FORM_MACROS_SVH

`ifndef NO_ASSERTIONS
// The condition implies the consequence in the same cycle.
`define FIR_DF_ASSERT_SAME(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("fir_df: same-cycle check failed");
// The condition implies the consequence in the next cycle.
`define FIR_DF_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("fir_df: next-cycle check failed");
`else
`define FIR_DF_ASSERT_SAME(lbl, cond, cons)
`define FIR_DF_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

[hdl/fir_df_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fir_df_pkg;

  // Filter geometry and number formats.
  localparam int NUM_TAPS     = 65;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int COEF_INDEX_W = 7;

  // Derived widths for the multiply-accumulate path.
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS) + 1;
  localparam int CNT_W  = $clog2(NUM_TAPS);

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_FILTER = 2'd0,
    OP_COEF   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [COEF_INDEX_W-1:0]   coef_index;
    logic signed [COEF_W-1:0]  coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_value;
    logic                       saturated;
  } out_item_t;

  // Controls broadcast to every cell of the tap chain.
  typedef struct packed {
    logic shift;
    logic clear;
    logic coef_wr;
    logic rotate;
  } cell_ctrl_t;

  // Controls for the multiply-accumulate unit.
  typedef struct packed {
    logic clr;
    logic mul_en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[hdl/fir_filter_direct_form.sv]
// Direct-form FIR filter, NUM_TAPS taps, one shared multiply-accumulate unit.
// Sample item: the chain rotates once through the single multiplier (S_MAC),
// the last product is added in S_DRAIN, and S_OUT loads the output register;
// no new item is accepted until that load. Coefficient and clear items give
// no result. Reset (synchronous, active high) zeroes all coefficients and the
// sample history and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "fir_filter_direct_form_macros.svh"

module fir_filter_direct_form
  import fir_df_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic [CNT_W-1:0]           cnt;
  logic                       in_fire;
  logic                       out_load;
  cell_ctrl_t                 cell_ctrl;
  mac_ctrl_t                  mac_ctrl;
  out_item_t                  mac_result;
  logic signed [COEF_W-1:0]   coef_q [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] tap_q  [NUM_TAPS];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  // Controls for the tap chain and the accumulator.
  always_comb begin
    cell_ctrl.shift   = in_fire && (in_item.operation == OP_FILTER);
    cell_ctrl.clear   = in_fire && (in_item.operation == OP_CLEAR);
    cell_ctrl.coef_wr = in_fire && (in_item.operation == OP_COEF);
    cell_ctrl.rotate  = (state == S_MAC);
    mac_ctrl.clr      = cell_ctrl.shift;
    mac_ctrl.mul_en   = (state == S_MAC);
  end

  // Chain of tap cells; cell 0 is the head that feeds the multiplier.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    logic signed [SAMPLE_W-1:0] shift_src;
    logic                       hit;

    if (k == 0) begin : g_head
      assign shift_src = in_item.sample_value;
    end else begin : g_body
      assign shift_src = tap_q[k-1];
    end

    assign hit = (32'(in_item.coef_index) == k);

    fir_df_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .coef_hit   (hit),
      .coef_wdata (in_item.coef_value),
      .shift_in   (shift_src),
      .rot_coef   (coef_q[(k + 1) % NUM_TAPS]),
      .rot_tap    (tap_q[(k + 1) % NUM_TAPS]),
      .coef       (coef_q[k]),
      .tap        (tap_q[k])
    );
  end

  fir_df_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef_q[0]),
    .tap    (tap_q[0]),
    .result (mac_result)
  );

  // Sequencer: one full rotation of the chain per sample item.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cell_ctrl.shift) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (cnt == CNT_W'(NUM_TAPS - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cell_ctrl.shift) begin
        cnt <= '0;
      end else if (state == S_MAC) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Output register holds a finished item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item <= mac_result;
    end
  end

  `FIR_DF_ASSERT_NEXT(a_sample_starts_mac, cell_ctrl.shift, state == S_MAC)
  `FIR_DF_ASSERT_SAME(a_drain_after_full_turn, state == S_DRAIN,
                      $past(state) == S_MAC && $past(cnt) == CNT_W'(NUM_TAPS - 1))
  `FIR_DF_ASSERT_NEXT(a_result_loaded, out_load, out_valid && state == S_IDLE)

endmodule

`default_nettype wire

[hdl/fir_df_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module fir_df_cell
  import fir_df_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cell_ctrl_t                 ctrl,
  input  wire logic                       coef_hit,
  input  wire logic signed [COEF_W-1:0]   coef_wdata,
  input  wire logic signed [SAMPLE_W-1:0] shift_in,
  input  wire logic signed [COEF_W-1:0]   rot_coef,
  input  wire logic signed [SAMPLE_W-1:0] rot_tap,
  output logic signed [COEF_W-1:0]        coef,
  output logic signed [SAMPLE_W-1:0]      tap
);

  // One tap: a coefficient and the delayed sample it multiplies. While the
  // chain rotates, both move one cell toward the head; otherwise the sample
  // shifts down the delay line or is cleared, and the coefficient can be rewritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      tap  <= '0;
    end else if (ctrl.rotate) begin
      coef <= rot_coef;
      tap  <= rot_tap;
    end else begin
      if (ctrl.coef_wr && coef_hit) begin
        coef <= coef_wdata;
      end
      if (ctrl.clear) begin
        tap <= '0;
      end else if (ctrl.shift) begin
        tap <= shift_in;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/fir_df_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module fir_df_mac
  import fir_df_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mac_ctrl_t                  ctrl,
  input  wire logic signed [COEF_W-1:0]   coef,
  input  wire logic signed [SAMPLE_W-1:0] tap,
  output out_item_t                       result
);

  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_W - 2);

  logic signed [PROD_W-1:0]        prod;
  logic                            prod_vld;
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]         shifted;
  logic [ACC_W-SAMPLE_W:0]         hi_bits;
  logic                            clip;

  // Registered product of the tap currently at the head of the chain.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * tap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.mul_en;
    end
  end

  // Exact accumulation of the products, one per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Round half up back to the sample format, then clip to its range.
  always_comb begin
    rnd     = acc + RND_HALF;
    shifted = rnd >>> (COEF_W - 1);
    hi_bits = shifted[ACC_W-1:SAMPLE_W-1];
    clip    = !((&hi_bits) || !(|hi_bits));
    result.saturated = clip;
    if (clip) begin
      result.filtered_value = {shifted[ACC_W-1], {(SAMPLE_W - 1){~shifted[ACC_W-1]}}};
    end else begin
      result.filtered_value = shifted[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

[dv/fir_filter_direct_form_tb.sv]
`timescale 1ns / 1ps

module fir_filter_direct_form_tb;
  import fir_df_pkg::*;

  // Operation code that the block must ignore.
  localparam op_t OP_UNUSED = op_t'(2'd3);
  // Cycles without any accepted item or taken result before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Shadow copy of the filter state.
  logic signed [COEF_W-1:0]   tap_coefs [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] past_samples [NUM_TAPS-1];
  out_item_t                  pending_filtered [$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  bit no_idle = 1'b0;

  fir_filter_direct_form u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Applies one accepted item to the shadow state and queues the filtered sample it yields.
  function automatic void fir_predict(in_item_t item);
    longint    acc;
    out_item_t res;
    case (item.operation)
      OP_COEF: begin
        if (item.coef_index < NUM_TAPS) tap_coefs[item.coef_index] = item.coef_value;
      end
      OP_CLEAR: begin
        foreach (past_samples[k]) past_samples[k] = '0;
      end
      OP_FILTER: begin
        acc = longint'(tap_coefs[0]) * longint'(item.sample_value);
        for (int k = 1; k < NUM_TAPS; k++) begin
          acc += longint'(tap_coefs[k]) * longint'(past_samples[k-1]);
        end
        // Round half up, then floor back to the sample format.
        acc = (acc + (longint'(1) << (COEF_W - 2))) >>> (COEF_W - 1);
        res.saturated = 1'b0;
        if (acc > longint'(2 ** (SAMPLE_W - 1) - 1)) begin
          acc = longint'(2 ** (SAMPLE_W - 1) - 1);
          res.saturated = 1'b1;
        end else if (acc < -longint'(2 ** (SAMPLE_W - 1))) begin
          acc = -longint'(2 ** (SAMPLE_W - 1));
          res.saturated = 1'b1;
        end
        res.filtered_value = acc[SAMPLE_W-1:0];
        for (int k = NUM_TAPS - 2; k > 0; k--) past_samples[k] = past_samples[k-1];
        past_samples[0] = item.sample_value;
        pending_filtered.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_item_t make_item(op_t op, logic [SAMPLE_W-1:0] sample,
                                         logic [COEF_INDEX_W-1:0] index,
                                         logic [COEF_W-1:0] coef);
    in_item_t item;
    item.operation    = op;
    item.sample_value = sample;
    item.coef_index   = index;
    item.coef_value   = coef;
    return item;
  endfunction

  // Random 16-bit word: sometimes an extreme, otherwise within +/- mag.
  function automatic logic [15:0] random_word(int unsigned mag);
    int v;
    case ($urandom_range(0, 7))
      0: v = -32768;
      1: v = 32767;
      default: begin
        if (mag >= 32768) v = int'($urandom_range(0, 65535)) - 32768;
        else v = int'($urandom_range(0, 2 * mag - 1)) - int'(mag);
      end
    endcase
    return v[15:0];
  endfunction

  // Offers one item after a random gap, none under no_idle, and waits for it to be accepted.
  task automatic offer_item(in_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    fir_predict(item);
  endtask

  // Stops offering items until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_filtered.size() != 0);
  endtask

  // Extremes of samples and taps, ignored writes, the unused code and rounding of halves.
  task automatic test_tap_extremes();
    offer_item(make_item(OP_FILTER, 16'h7FFF, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'h8000, 7'd127, 16'hFFFF));
    offer_item(make_item(OP_COEF, 16'h5555, 7'd0, 16'h8000));
    offer_item(make_item(OP_COEF, 16'hAAAA, 7'd64, 16'h7FFF));
    offer_item(make_item(OP_COEF, 16'h0000, 7'd65, 16'h1234));
    offer_item(make_item(OP_COEF, 16'hFFFF, 7'd127, 16'hFFFF));
    offer_item(make_item(OP_UNUSED, 16'h7FFF, 7'd1, 16'h7FFF));
    offer_item(make_item(OP_FILTER, 16'h8000, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'h7FFF, 7'd0, 16'h0000));
    offer_item(make_item(OP_COEF, 16'h0000, 7'd0, 16'h0001));
    offer_item(make_item(OP_FILTER, 16'h4000, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'hC000, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'h0000, 7'd0, 16'h0000));
  endtask

  // A clear drops the history but keeps the taps.
  task automatic test_clear_history();
    offer_item(make_item(OP_COEF, 16'h0000, 7'd1, 16'h4000));
    offer_item(make_item(OP_FILTER, 16'd20000, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'd30000, 7'd0, 16'h0000));
    offer_item(make_item(OP_CLEAR, 16'h1111, 7'd1, 16'h2222));
    offer_item(make_item(OP_FILTER, 16'h0000, 7'd0, 16'h0000));
    offer_item(make_item(OP_FILTER, 16'd1000, 7'd0, 16'h0000));
  endtask

  // The receiver holds off while samples keep coming, then the sender waits for a full drain.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = LONG_HOLD_CYCLES;
    repeat (30) offer_item(make_item(OP_FILTER, random_word(32768), 7'd0, 16'h0000));
    drain_results();
    no_idle = 1'b0;
  endtask

  // Rounds of a full tap load followed by a mixed stream of items.
  task automatic test_random_stream();
    int unsigned mag;
    int          pick;
    in_item_t    item;
    for (int round = 0; round < 8; round++) begin
      case (round)
        0: mag = 64;
        3: mag = 8192;
        5: mag = 32768;
        6: mag = 256;
        default: mag = 1024;
      endcase
      no_idle = (round % 3 == 2);
      for (int k = 0; k < NUM_TAPS; k++) begin
        offer_item(make_item(OP_COEF, SAMPLE_W'($urandom), k[COEF_INDEX_W-1:0],
                             random_word(mag)));
      end
      repeat (140) begin
        item = make_item(OP_FILTER, random_word(32768), COEF_INDEX_W'($urandom),
                         random_word(mag));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          item.operation = OP_FILTER;
        end else if (pick < 90) begin
          item.operation = OP_COEF;
          if ($urandom_range(0, 9) != 0) begin
            item.coef_index = COEF_INDEX_W'($urandom_range(0, NUM_TAPS - 1));
          end else begin
            item.coef_index = COEF_INDEX_W'($urandom_range(NUM_TAPS, 127));
          end
        end else if (pick < 95) begin
          item.operation = OP_CLEAR;
        end else begin
          item.operation = OP_UNUSED;
        end
        offer_item(item);
      end
    end
    no_idle = 1'b0;
  endtask

  // Result receiver: random stalls per item, with an occasional long hold.
  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted result with the oldest expected one.
  always @(posedge clk) begin : check_results
    out_item_t wanted;
    if (!rst && out_valid && out_ready) begin
      if (pending_filtered.size() == 0) begin
        $error("unexpected result: filtered_value %0d, saturated %0b",
               out_item.filtered_value, out_item.saturated);
        mismatch_count++;
      end else begin
        wanted = pending_filtered.pop_front();
        if (out_item.filtered_value !== wanted.filtered_value) begin
          $error("filtered_value: expected %0d, actual %0d",
                 wanted.filtered_value, out_item.filtered_value);
          mismatch_count++;
        end
        if (out_item.saturated !== wanted.saturated) begin
          $error("saturated: expected %0b, actual %0b", wanted.saturated, out_item.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Ends a hung run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("fir_filter_direct_form_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (tap_coefs[k]) tap_coefs[k] = '0;
    foreach (past_samples[k]) past_samples[k] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_tap_extremes();
    test_clear_history();
    test_backpressure();
    test_random_stream();
    drain_results();
    repeat (NUM_TAPS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fir_filter_direct_form_tb passed");
    end else begin
      $display("fir_filter_direct_form_tb failed");
    end
    $finish;
  end

endmodule

[fir_filter_direct_form.f]
+incdir+hdl
hdl/fir_df_pkg.sv
hdl/fir_df_cell.sv
hdl/fir_df_mac.sv
hdl/fir_filter_direct_form.sv
dv/fir_filter_direct_form_tb.sv
